// ----- rtl/core/hrp_pkg.sv -----
// Shared types, codes and helper functions of the HTTP request parser.
package hrp_pkg;

	localparam int LENGTH_BITS_DEF = 31;
	localparam int BODY_W = 31;
	localparam int VER_W = 16;
	localparam int KEY_LEN = 14;

	typedef enum logic [0:0] {
		OP_DATA    = 1'b0,
		OP_RESTART = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_PENDING   = 2'd0,
		ST_COMPLETE  = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CL_NONE   = 3'd0,
		CL_METHOD = 3'd1,
		CL_URI    = 3'd2,
		CL_NAME   = 3'd3,
		CL_VALUE  = 3'd4,
		CL_BODY   = 3'd5
	} class_t;

	typedef enum logic [20:0] {
		S_METHOD_START = 21'h000001,
		S_METHOD       = 21'h000002,
		S_URI          = 21'h000004,
		S_VH           = 21'h000008,
		S_VT1          = 21'h000010,
		S_VT2          = 21'h000020,
		S_VP           = 21'h000040,
		S_VSLASH       = 21'h000080,
		S_MAJ_START    = 21'h000100,
		S_MAJ          = 21'h000200,
		S_MIN_START    = 21'h000400,
		S_MIN          = 21'h000800,
		S_NL1          = 21'h001000,
		S_LINE_START   = 21'h002000,
		S_LWS          = 21'h004000,
		S_NAME         = 21'h008000,
		S_SPACE        = 21'h010000,
		S_VALUE        = 21'h020000,
		S_NL2          = 21'h040000,
		S_NL3          = 21'h080000,
		S_BODY         = 21'h100000
	} state_t;

	typedef struct packed {
		logic              valid;
		opcode_t           opcode;
		logic [7:0]        data_byte;
	} item_t;

	typedef struct packed {
		status_t           status;
		class_t            byte_class;
		logic [7:0]        byte_out;
		logic              new_header;
		logic [VER_W-1:0]  version_major;
		logic [VER_W-1:0]  version_minor;
		logic [BODY_W-1:0] body_left;
	} result_t;

	function automatic logic ctl_byte(input logic [7:0] c);
		return (c <= 8'd31) || (c == 8'd127);
	endfunction

	function automatic logic digit_byte(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic separator_byte(input logic [7:0] c);
		return c inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", " ", 8'h09};
	endfunction

	function automatic logic token_byte(input logic [7:0] c);
		return (c <= 8'd127) && !ctl_byte(c) && !separator_byte(c);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
	endfunction

	function automatic logic [7:0] key_char(input logic [3:0] pos);
		logic [7:0] k;
		case (pos)
			4'd0: k = "c";
			4'd1: k = "o";
			4'd2: k = "n";
			4'd3: k = "t";
			4'd4: k = "e";
			4'd5: k = "n";
			4'd6: k = "t";
			4'd7: k = "-";
			4'd8: k = "l";
			4'd9: k = "e";
			4'd10: k = "n";
			4'd11: k = "g";
			4'd12: k = "t";
			4'd13: k = "h";
			default: k = 8'd0;
		endcase
		return k;
	endfunction

	function automatic logic [VER_W-1:0] ver_step(input logic [VER_W-1:0] v,
			input logic [7:0] c);
		logic [VER_W+3:0] n;
		n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{VER_W{1'b0}}, c[3:0]};
		return (|n[VER_W+3:VER_W]) ? {VER_W{1'b1}} : n[VER_W-1:0];
	endfunction

endpackage

// ----- rtl/core/hrp_in_stage.sv -----
// Input register stage of the HTTP request parser.
module hrp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            opcode,
	input  logic [7:0]      data_byte,
	input  logic            advance,
	output hrp_pkg::item_t  item_s1
);

	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] byte_s1;
	logic       load;

	assign in_stall = valid_s1 && !advance;
	assign load = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			opcode_s1 <= opcode;
			byte_s1 <= data_byte;
		end
	end

	assign item_s1.valid = valid_s1;
	assign item_s1.opcode = hrp_pkg::opcode_t'(opcode_s1);
	assign item_s1.data_byte = byte_s1;

endmodule

// ----- rtl/core/hrp_core.sv -----
// Parser state registers and the per-byte next-state and result logic.
module hrp_core #(
	parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             proc,
	input  hrp_pkg::item_t   item_s1,
	output hrp_pkg::result_t res
);

	localparam int LW = LENGTH_BITS + 4;

	hrp_pkg::state_t                state_q, state_d;
	logic [LENGTH_BITS-1:0]         body_q, body_d;
	logic [hrp_pkg::VER_W-1:0]      maj_q, maj_d, min_q, min_d;
	logic                           seen_q, seen_d;
	logic [3:0]                     pos_q, pos_d;
	logic                           match_q, match_d;
	logic                           inlen_q, inlen_d;
	logic [LENGTH_BITS-1:0]         acc_q, acc_d;
	logic                           found_q, found_d;
	logic                           hasd_q, hasd_d;
	logic                           inv_q, inv_d;

	logic [7:0]                     c;
	logic                           bad;
	logic                           nh;
	hrp_pkg::status_t               st;
	hrp_pkg::class_t                cls;
	logic [LW-1:0]                  acc_wide;
	logic                           acc_ovf;
	logic                           name_hit;
	logic                           first_hit;
	logic                           vb_inlen_inv, vb_has, vb_inv;
	logic [LENGTH_BITS-1:0]         vb_acc;

	assign c = item_s1.data_byte;
	assign acc_wide = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ {{LENGTH_BITS{1'b0}}, c[3:0]};
	assign acc_ovf = |acc_wide[LW-1:LENGTH_BITS];
	assign name_hit = match_q && (pos_q < 4'(hrp_pkg::KEY_LEN))
		&& (hrp_pkg::fold(c) == hrp_pkg::key_char(pos_q));
	assign first_hit = hrp_pkg::fold(c) == hrp_pkg::key_char(4'd0);

	always_comb begin
		vb_inlen_inv = inv_q;
		vb_has = hasd_q;
		vb_acc = acc_q;
		if (inlen_q) begin
			if (!hrp_pkg::digit_byte(c)) begin
				vb_inlen_inv = 1'b1;
			end else begin
				vb_has = 1'b1;
				if (!inv_q) begin
					if (acc_ovf) begin
						vb_inlen_inv = 1'b1;
					end else begin
						vb_acc = acc_wide[LENGTH_BITS-1:0];
					end
				end
			end
		end
		vb_inv = vb_inlen_inv;
	end

	always_comb begin
		state_d = state_q;
		body_d = body_q;
		maj_d = maj_q;
		min_d = min_q;
		seen_d = seen_q;
		pos_d = pos_q;
		match_d = match_q;
		inlen_d = inlen_q;
		acc_d = acc_q;
		found_d = found_q;
		hasd_d = hasd_q;
		inv_d = inv_q;
		st = hrp_pkg::ST_PENDING;
		cls = hrp_pkg::CL_NONE;
		nh = 1'b0;
		bad = 1'b0;
		if (item_s1.opcode == hrp_pkg::OP_RESTART) begin
			state_d = hrp_pkg::S_METHOD_START;
			body_d = '0;
			maj_d = '0;
			min_d = '0;
			seen_d = 1'b0;
			pos_d = '0;
			match_d = 1'b0;
			inlen_d = 1'b0;
			acc_d = '0;
			found_d = 1'b0;
			hasd_d = 1'b0;
			inv_d = 1'b0;
		end else begin
			case (state_q)
				hrp_pkg::S_METHOD_START: begin
					if (!hrp_pkg::token_byte(c)) bad = 1'b1;
					else begin
						state_d = hrp_pkg::S_METHOD;
						cls = hrp_pkg::CL_METHOD;
					end
				end
				hrp_pkg::S_METHOD: begin
					if (c == " ") state_d = hrp_pkg::S_URI;
					else if (!hrp_pkg::token_byte(c)) bad = 1'b1;
					else cls = hrp_pkg::CL_METHOD;
				end
				hrp_pkg::S_URI: begin
					if (c == " ") state_d = hrp_pkg::S_VH;
					else if (hrp_pkg::ctl_byte(c)) bad = 1'b1;
					else cls = hrp_pkg::CL_URI;
				end
				hrp_pkg::S_VH: begin
					if (c == "H") state_d = hrp_pkg::S_VT1;
					else bad = 1'b1;
				end
				hrp_pkg::S_VT1: begin
					if (c == "T") state_d = hrp_pkg::S_VT2;
					else bad = 1'b1;
				end
				hrp_pkg::S_VT2: begin
					if (c == "T") state_d = hrp_pkg::S_VP;
					else bad = 1'b1;
				end
				hrp_pkg::S_VP: begin
					if (c == "P") state_d = hrp_pkg::S_VSLASH;
					else bad = 1'b1;
				end
				hrp_pkg::S_VSLASH: begin
					if (c == "/") begin
						maj_d = '0;
						min_d = '0;
						state_d = hrp_pkg::S_MAJ_START;
					end else bad = 1'b1;
				end
				hrp_pkg::S_MAJ_START: begin
					if (hrp_pkg::digit_byte(c)) begin
						maj_d = hrp_pkg::ver_step(maj_q, c);
						state_d = hrp_pkg::S_MAJ;
					end else bad = 1'b1;
				end
				hrp_pkg::S_MAJ: begin
					if (c == ".") state_d = hrp_pkg::S_MIN_START;
					else if (hrp_pkg::digit_byte(c)) maj_d = hrp_pkg::ver_step(maj_q, c);
					else bad = 1'b1;
				end
				hrp_pkg::S_MIN_START: begin
					if (hrp_pkg::digit_byte(c)) begin
						min_d = hrp_pkg::ver_step(min_q, c);
						state_d = hrp_pkg::S_MIN;
					end else bad = 1'b1;
				end
				hrp_pkg::S_MIN: begin
					if (c == 8'h0d) state_d = hrp_pkg::S_NL1;
					else if (hrp_pkg::digit_byte(c)) min_d = hrp_pkg::ver_step(min_q, c);
					else bad = 1'b1;
				end
				hrp_pkg::S_NL1, hrp_pkg::S_NL2: begin
					if (c == 8'h0a) state_d = hrp_pkg::S_LINE_START;
					else bad = 1'b1;
				end
				hrp_pkg::S_LINE_START: begin
					if (c == 8'h0d) state_d = hrp_pkg::S_NL3;
					else if (seen_q && (c == " " || c == 8'h09)) state_d = hrp_pkg::S_LWS;
					else if (!hrp_pkg::token_byte(c)) bad = 1'b1;
					else begin
						seen_d = 1'b1;
						inlen_d = 1'b0;
						pos_d = first_hit ? 4'd1 : 4'd0;
						match_d = first_hit;
						state_d = hrp_pkg::S_NAME;
						cls = hrp_pkg::CL_NAME;
						nh = 1'b1;
					end
				end
				hrp_pkg::S_LWS: begin
					if (c == 8'h0d) state_d = hrp_pkg::S_NL2;
					else if (c == " " || c == 8'h09) state_d = hrp_pkg::S_LWS;
					else if (hrp_pkg::ctl_byte(c)) bad = 1'b1;
					else begin
						inv_d = vb_inv;
						hasd_d = vb_has;
						acc_d = vb_acc;
						state_d = hrp_pkg::S_VALUE;
						cls = hrp_pkg::CL_VALUE;
					end
				end
				hrp_pkg::S_NAME: begin
					if (c == ":") begin
						state_d = hrp_pkg::S_SPACE;
						if (match_q && pos_q == 4'(hrp_pkg::KEY_LEN)) begin
							inlen_d = 1'b1;
							found_d = 1'b1;
							acc_d = '0;
							hasd_d = 1'b0;
							inv_d = 1'b0;
						end
					end else if (!hrp_pkg::token_byte(c)) bad = 1'b1;
					else begin
						if (name_hit) pos_d = pos_q + 4'd1;
						else match_d = 1'b0;
						cls = hrp_pkg::CL_NAME;
					end
				end
				hrp_pkg::S_SPACE: begin
					if (c == " ") state_d = hrp_pkg::S_VALUE;
					else bad = 1'b1;
				end
				hrp_pkg::S_VALUE: begin
					if (c == 8'h0d) state_d = hrp_pkg::S_NL2;
					else if (hrp_pkg::ctl_byte(c)) bad = 1'b1;
					else begin
						inv_d = vb_inv;
						hasd_d = vb_has;
						acc_d = vb_acc;
						cls = hrp_pkg::CL_VALUE;
					end
				end
				hrp_pkg::S_NL3: begin
					if (c != 8'h0a) bad = 1'b1;
					else if (found_q && (inv_q || !hasd_q)) bad = 1'b1;
					else begin
						body_d = found_q ? acc_q : '0;
						if (found_q && acc_q != '0) state_d = hrp_pkg::S_BODY;
						else st = hrp_pkg::ST_COMPLETE;
					end
				end
				hrp_pkg::S_BODY: begin
					if (body_q != '0) begin
						body_d = body_q - 1'b1;
						cls = hrp_pkg::CL_BODY;
						if (body_q == LENGTH_BITS'(1)) st = hrp_pkg::ST_COMPLETE;
					end else st = hrp_pkg::ST_COMPLETE;
				end
				default: bad = 1'b1;
			endcase
			if (bad) begin
				state_d = state_q;
				body_d = body_q;
				maj_d = maj_q;
				min_d = min_q;
				seen_d = seen_q;
				pos_d = pos_q;
				match_d = match_q;
				inlen_d = inlen_q;
				acc_d = acc_q;
				found_d = found_q;
				hasd_d = hasd_q;
				inv_d = inv_q;
				st = hrp_pkg::ST_MALFORMED;
				cls = hrp_pkg::CL_NONE;
				nh = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrp_pkg::S_METHOD_START;
			body_q <= '0;
			maj_q <= '0;
			min_q <= '0;
			seen_q <= 1'b0;
			pos_q <= '0;
			match_q <= 1'b0;
			inlen_q <= 1'b0;
			acc_q <= '0;
			found_q <= 1'b0;
			hasd_q <= 1'b0;
			inv_q <= 1'b0;
		end else if (proc) begin
			state_q <= state_d;
			body_q <= body_d;
			maj_q <= maj_d;
			min_q <= min_d;
			seen_q <= seen_d;
			pos_q <= pos_d;
			match_q <= match_d;
			inlen_q <= inlen_d;
			acc_q <= acc_d;
			found_q <= found_d;
			hasd_q <= hasd_d;
			inv_q <= inv_d;
		end
	end

	assign res.status = st;
	assign res.byte_class = cls;
	assign res.byte_out = (cls != hrp_pkg::CL_NONE) ? c : 8'd0;
	assign res.new_header = nh;
	assign res.version_major = maj_d;
	assign res.version_minor = min_d;
	assign res.body_left = hrp_pkg::BODY_W'(body_d);

`ifndef ASSERT_OFF
	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		proc && item_s1.opcode == hrp_pkg::OP_RESTART |=> state_q == hrp_pkg::S_METHOD_START)
		else $error("restart did not return the parser to the method start");
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		proc && item_s1.opcode == hrp_pkg::OP_DATA && state_q == hrp_pkg::S_BODY
		&& body_q != '0 |=> body_q == $past(body_q) - 1'b1)
		else $error("body byte did not decrement the body count");
	a_malformed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		proc && res.status == hrp_pkg::ST_MALFORMED |=> $stable(state_q))
		else $error("malformed byte changed the parse state");
`endif

endmodule

// ----- rtl/core/http_request_parser_unit.sv -----
// Top level of the HTTP request parser: input stage, parser core and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  input    | in_valid, in_stall  | opcode, data_byte
//  output   | out_valid, out_stall| status, byte_class, byte_out, new_header,
//           |                     | version_major, version_minor, body_left
//
// One byte per cycle is taken while in_stall is low; each byte passes the input register, then the result register.
// The parse state is updated as a byte moves from the input register to the result register.
// While a result waits, the input register still takes a transaction if it is empty, and then it stalls the input.
// Reset clears the valid flags and returns the parser to the method start.
module http_request_parser_unit #(
	parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [2:0]                   byte_class,
	output logic [7:0]                   byte_out,
	output logic                         new_header,
	output logic [hrp_pkg::VER_W-1:0]    version_major,
	output logic [hrp_pkg::VER_W-1:0]    version_minor,
	output logic [hrp_pkg::BODY_W-1:0]   body_left
);

	hrp_pkg::item_t   item_s1;
	hrp_pkg::result_t res;
	hrp_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;
	logic             proc;

	assign advance = !(out_valid_q && out_stall);
	assign proc = advance && item_s1.valid;

	hrp_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.advance   (advance),
		.item_s1   (item_s1)
	);

	hrp_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc    (proc),
		.item_s1 (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= item_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign byte_class = res_q.byte_class;
	assign byte_out = res_q.byte_out;
	assign new_header = res_q.new_header;
	assign version_major = res_q.version_major;
	assign version_minor = res_q.version_minor;
	assign body_left = res_q.body_left;

`ifndef ASSERT_OFF
	a_malformed_untagged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hrp_pkg::ST_MALFORMED |-> byte_class == hrp_pkg::CL_NONE
		&& !new_header)
		else $error("malformed result carries a byte class");
	a_new_header_name: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_header |-> byte_class == hrp_pkg::CL_NAME)
		else $error("new header flag on a byte that is not a header name");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_q))
		else $error("stalled result was overwritten");
`endif

endmodule

// ----- dv/http_request_parser_checker.sv -----
// Checker that follows the request byte stream, predicts each parser result and compares it.
`timescale 1ns / 1ps
module http_request_parser_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       opcode,
	input  logic [7:0]                 data_byte,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [1:0]                 status,
	input  logic [2:0]                 byte_class,
	input  logic [7:0]                 byte_out,
	input  logic                       new_header,
	input  logic [hrp_pkg::VER_W-1:0]  version_major,
	input  logic [hrp_pkg::VER_W-1:0]  version_minor,
	input  logic [hrp_pkg::BODY_W-1:0] body_left,
	output int                         fail_count,
	output int                         results_owed
);
	import hrp_pkg::*;

	localparam logic [8*KEY_LEN-1:0] LENGTH_KEY = "content-length";
	localparam logic [63:0] LENGTH_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
	localparam logic [7:0] TAB = 8'h09;
	localparam logic [7:0] LF = 8'h0A;
	localparam logic [7:0] CR = 8'h0D;
	localparam logic [7:0] SP = 8'h20;

	state_t            pstate;
	logic [BODY_W-1:0] body_cnt;
	logic [VER_W-1:0]  ver_maj;
	logic [VER_W-1:0]  ver_min;
	logic              hdr_seen;
	logic [3:0]        key_pos;
	logic              key_ok;
	logic              in_cl;
	logic [BODY_W-1:0] cl_acc;
	logic              cl_found;
	logic              cl_digit;
	logic              cl_bad;

	result_t owed_results[$];
	result_t want;
	int      mismatches = 0;
	logic    txn_bad;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c < 8'd32) || (c == 8'd127);
	endfunction

	function automatic logic dec_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
			"{", "}", SP, TAB: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_sep(c);
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
	endfunction

	function automatic logic [VER_W-1:0] vstep(input logic [VER_W-1:0] v, input logic [7:0] c);
		int unsigned n;
		n = 32'(v) * 32'd10 + 32'(c - 8'h30);
		return (n > 32'd65535) ? {VER_W{1'b1}} : n[VER_W-1:0];
	endfunction

	function automatic void clear_parser();
		pstate = S_METHOD_START;
		body_cnt = '0;
		ver_maj = '0;
		ver_min = '0;
		hdr_seen = 1'b0;
		key_pos = '0;
		key_ok = 1'b0;
		in_cl = 1'b0;
		cl_acc = '0;
		cl_found = 1'b0;
		cl_digit = 1'b0;
		cl_bad = 1'b0;
	endfunction

	function automatic void key_step(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		if (key_ok && (key_pos < KEY_LEN)) begin
			hit = (lower(c) == LENGTH_KEY[8*(KEY_LEN-1-int'(key_pos)) +: 8]);
		end
		if (hit) begin
			key_pos++;
		end else begin
			key_ok = 1'b0;
		end
	endfunction

	function automatic void value_step(input logic [7:0] c);
		logic [63:0] acc;
		if (in_cl) begin
			if (!dec_digit(c)) begin
				cl_bad = 1'b1;
			end else begin
				cl_digit = 1'b1;
				if (!cl_bad) begin
					acc = {33'd0, cl_acc} * 64'd10 + 64'(c - 8'h30);
					if (acc > LENGTH_MAX) begin
						cl_bad = 1'b1;
					end else begin
						cl_acc = acc[BODY_W-1:0];
					end
				end
			end
		end
	endfunction

	function automatic result_t parse_byte(input opcode_t op, input logic [7:0] c);
		result_t r;
		status_t st;
		class_t  cls;
		logic    nh;
		logic    bad;
		st = ST_PENDING;
		cls = CL_NONE;
		nh = 1'b0;
		bad = 1'b0;
		if (op == OP_RESTART) begin
			clear_parser();
		end else begin
			case (pstate)
				S_METHOD_START: begin
					if (!is_token(c)) bad = 1'b1;
					else begin
						pstate = S_METHOD;
						cls = CL_METHOD;
					end
				end
				S_METHOD: begin
					if (c == SP) pstate = S_URI;
					else if (!is_token(c)) bad = 1'b1;
					else cls = CL_METHOD;
				end
				S_URI: begin
					if (c == SP) pstate = S_VH;
					else if (is_ctl(c)) bad = 1'b1;
					else cls = CL_URI;
				end
				S_VH: begin
					if (c == "H") pstate = S_VT1;
					else bad = 1'b1;
				end
				S_VT1: begin
					if (c == "T") pstate = S_VT2;
					else bad = 1'b1;
				end
				S_VT2: begin
					if (c == "T") pstate = S_VP;
					else bad = 1'b1;
				end
				S_VP: begin
					if (c == "P") pstate = S_VSLASH;
					else bad = 1'b1;
				end
				S_VSLASH: begin
					if (c == "/") begin
						ver_maj = '0;
						ver_min = '0;
						pstate = S_MAJ_START;
					end else bad = 1'b1;
				end
				S_MAJ_START: begin
					if (dec_digit(c)) begin
						ver_maj = vstep(ver_maj, c);
						pstate = S_MAJ;
					end else bad = 1'b1;
				end
				S_MAJ: begin
					if (c == ".") pstate = S_MIN_START;
					else if (dec_digit(c)) ver_maj = vstep(ver_maj, c);
					else bad = 1'b1;
				end
				S_MIN_START: begin
					if (dec_digit(c)) begin
						ver_min = vstep(ver_min, c);
						pstate = S_MIN;
					end else bad = 1'b1;
				end
				S_MIN: begin
					if (c == CR) pstate = S_NL1;
					else if (dec_digit(c)) ver_min = vstep(ver_min, c);
					else bad = 1'b1;
				end
				S_NL1, S_NL2: begin
					if (c == LF) pstate = S_LINE_START;
					else bad = 1'b1;
				end
				S_LINE_START: begin
					if (c == CR) pstate = S_NL3;
					else if (hdr_seen && ((c == SP) || (c == TAB))) pstate = S_LWS;
					else if (!is_token(c)) bad = 1'b1;
					else begin
						hdr_seen = 1'b1;
						in_cl = 1'b0;
						key_pos = '0;
						key_ok = 1'b1;
						key_step(c);
						pstate = S_NAME;
						cls = CL_NAME;
						nh = 1'b1;
					end
				end
				S_LWS: begin
					if (c == CR) pstate = S_NL2;
					else if ((c == SP) || (c == TAB)) pstate = S_LWS;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						value_step(c);
						pstate = S_VALUE;
						cls = CL_VALUE;
					end
				end
				S_NAME: begin
					if (c == ":") begin
						pstate = S_SPACE;
						if (key_ok && (key_pos == KEY_LEN)) begin
							in_cl = 1'b1;
							cl_found = 1'b1;
							cl_acc = '0;
							cl_digit = 1'b0;
							cl_bad = 1'b0;
						end
					end else if (!is_token(c)) bad = 1'b1;
					else begin
						key_step(c);
						cls = CL_NAME;
					end
				end
				S_SPACE: begin
					if (c == SP) pstate = S_VALUE;
					else bad = 1'b1;
				end
				S_VALUE: begin
					if (c == CR) pstate = S_NL2;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						value_step(c);
						cls = CL_VALUE;
					end
				end
				S_NL3: begin
					if (c != LF) bad = 1'b1;
					else if (cl_found && (cl_bad || !cl_digit)) bad = 1'b1;
					else begin
						body_cnt = cl_found ? cl_acc : '0;
						if (body_cnt != '0) pstate = S_BODY;
						else st = ST_COMPLETE;
					end
				end
				S_BODY: begin
					if (body_cnt != '0) begin
						body_cnt--;
						cls = CL_BODY;
						if (body_cnt == '0) st = ST_COMPLETE;
					end else st = ST_COMPLETE;
				end
				default: bad = 1'b1;
			endcase
		end
		if (bad) begin
			st = ST_MALFORMED;
			cls = CL_NONE;
			nh = 1'b0;
		end
		r.status = st;
		r.byte_class = cls;
		r.byte_out = (cls != CL_NONE) ? c : 8'd0;
		r.new_header = nh;
		r.version_major = ver_maj;
		r.version_minor = ver_min;
		r.body_left = body_cnt;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, got_v);
			txn_bad = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			owed_results.delete();
			results_owed <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result transaction, status %0d, class %0d",
						$time, status, byte_class);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					txn_bad = 1'b0;
					check_field("status", want.status, status);
					check_field("byte_class", want.byte_class, byte_class);
					check_field("byte_out", want.byte_out, byte_out);
					check_field("new_header", want.new_header, new_header);
					check_field("version_major", want.version_major, version_major);
					check_field("version_minor", want.version_minor, version_minor);
					check_field("body_left", want.body_left, body_left);
					if (txn_bad) mismatches++;
				end
			end
			if (in_valid && !in_stall) begin
				owed_results.insert(owed_results.size(),
					parse_byte(opcode_t'(opcode), data_byte));
			end
			results_owed <= owed_results.size();
		end
		fail_count <= mismatches;
	end

endmodule

// ----- dv/tb_http_request_parser_unit.sv -----
// Testbench top for the HTTP request parser: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_http_request_parser_unit;
	import hrp_pkg::*;

	typedef struct packed {
		opcode_t    op;
		logic [7:0] b;
	} txn_t;

	localparam logic [7:0] TAB = 8'h09;
	localparam logic [7:0] LF = 8'h0A;
	localparam logic [7:0] CR = 8'h0D;
	localparam logic [7:0] SP = 8'h20;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                opcode = 1'b0;
	logic [7:0]          data_byte = 8'd0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [2:0]          byte_class;
	logic [7:0]          byte_out;
	logic                new_header;
	logic [VER_W-1:0]    version_major;
	logic [VER_W-1:0]    version_minor;
	logic [BODY_W-1:0]   body_left;
	int                  fail_count;
	int                  results_owed;

	txn_t  req[$];
	txn_t  stim[$];
	string tokens = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_`|~";

	always #4 clk = ~clk;

	http_request_parser_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.byte_class    (byte_class),
		.byte_out      (byte_out),
		.new_header    (new_header),
		.version_major (version_major),
		.version_minor (version_minor),
		.body_left     (body_left)
	);

	http_request_parser_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.byte_class    (byte_class),
		.byte_out      (byte_out),
		.new_header    (new_header),
		.version_major (version_major),
		.version_minor (version_minor),
		.body_left     (body_left),
		.fail_count    (fail_count),
		.results_owed  (results_owed)
	);

	function automatic void add(input opcode_t op, input logic [7:0] b);
		txn_t t;
		t.op = op;
		t.b = b;
		req.insert(req.size(), t);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) add(OP_DATA, s[i]);
	endfunction

	function automatic void add_crlf();
		add(OP_DATA, CR);
		add(OP_DATA, LF);
	endfunction

	function automatic logic [7:0] any_token();
		return tokens[$urandom_range(0, tokens.len() - 1)];
	endfunction

	function automatic logic [7:0] text_byte(input int lowest);
		logic [7:0] c;
		c = 8'($urandom_range(lowest, 255));
		return (c == 8'd127) ? "~" : c;
	endfunction

	initial begin : timeout
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin : receiver
		int phase;
		int span;
		int pct;
		phase = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (phase == 0) begin
				span = 40;
				pct = 0;
			end else if (phase == 1) begin
				span = 80;
				pct = 100;
			end else begin
				span = $urandom_range(10, 60);
				case ($urandom_range(0, 5))
					0: pct = 100;
					1, 2: pct = 0;
					default: pct = $urandom_range(10, 70);
				endcase
			end
			phase++;
			repeat (span) begin
				out_stall <= ($urandom_range(0, 99) < pct);
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int      kind;
		int      n;
		int      gap;
		int      burst;
		int      i;
		longint  body_len;
		logic    is_len;
		logic [7:0] c;
		string   key;
		string   val;
		txn_t    t;

		add(OP_RESTART, 8'hFF);
		add(OP_DATA, 8'hFF);
		add(OP_DATA, 8'h00);
		add_text("G");
		add(OP_DATA, SP);
		add(OP_DATA, 8'h80);
		add(OP_DATA, 8'hFF);
		add_text(" HTTP/1.1");
		add_crlf();
		add_crlf();
		add(OP_RESTART, 8'h00);
		stim = req;
		req.delete();

		while (stim.size() < 770) begin
			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				repeat ($urandom_range(1, 12)) begin
					add(($urandom_range(0, 15) == 0) ? OP_RESTART : OP_DATA,
						8'($urandom_range(0, 255)));
				end
			end else begin
				if ($urandom_range(0, 7) != 0) add(OP_RESTART, 8'($urandom));
				repeat ($urandom_range(1, 6)) add(OP_DATA, any_token());
				add(OP_DATA, SP);
				repeat ($urandom_range(1, 8)) add(OP_DATA, text_byte(33));
				add_text(" HTTP/");
				add_text($sformatf("%0d", ($urandom_range(0, 9) == 0) ?
					$urandom_range(6000, 999999) : $urandom_range(0, 12)));
				add_text(".");
				add_text($sformatf("%0d", ($urandom_range(0, 9) == 0) ?
					$urandom_range(6000, 999999) : $urandom_range(0, 12)));
				add_crlf();
				body_len = 0;
				repeat ($urandom_range(0, 4)) begin
					is_len = ($urandom_range(0, 2) == 0);
					if (is_len) begin
						key = "content-length";
						for (i = 0; i < key.len(); i++) begin
							c = key[i];
							if ((c >= "a") && (c <= "z") && ($urandom_range(0, 1) == 1))
								c = c - 8'd32;
							add(OP_DATA, c);
						end
						add_text(": ");
						case ($urandom_range(0, 9))
							0: begin val = "0"; body_len = 0; end
							1: begin val = "2147483647"; body_len = 2147483647; end
							2: begin val = "2147483648"; body_len = -1; end
							3: begin val = "99999999999"; body_len = -1; end
							4: begin val = ""; body_len = -1; end
							5: begin val = $sformatf(" %0d", $urandom_range(1, 9)); body_len = -1; end
							6: begin val = $sformatf("%0dx", $urandom_range(1, 9)); body_len = -1; end
							7: begin
								body_len = $urandom_range(1, 40);
								val = $sformatf("000000000000%0d", body_len);
							end
							default: begin
								body_len = $urandom_range(1, 40);
								val = $sformatf("%0d", body_len);
							end
						endcase
						add_text(val);
					end else begin
						case ($urandom_range(0, 3))
							0: add_text("Content-Len");
							1: add_text("content-lengthy");
							default: repeat ($urandom_range(1, 8)) add(OP_DATA, any_token());
						endcase
						add_text(": ");
						repeat ($urandom_range(0, 8)) add(OP_DATA, text_byte(32));
					end
					if ($urandom_range(0, 4) == 0) begin
						add_crlf();
						add(OP_DATA, ($urandom_range(0, 1) == 1) ? SP : TAB);
						repeat ($urandom_range(0, 2)) add(OP_DATA, SP);
						if (is_len) begin
							add_text($sformatf("%0d", $urandom_range(0, 9)));
							body_len = -1;
						end else begin
							repeat ($urandom_range(1, 4)) add(OP_DATA, text_byte(33));
						end
					end
					add_crlf();
				end
				add_crlf();
				if (body_len < 0) n = $urandom_range(0, 3);
				else n = ((body_len > 40) ? 40 : int'(body_len)) + $urandom_range(0, 2);
				repeat (n) add(OP_DATA, 8'($urandom));
				if ((kind >= 7) && (req.size() > 1)) begin
					i = $urandom_range(1, req.size() - 1);
					req[i].b = 8'($urandom);
				end
			end
			stim = {stim, req};
			req.delete();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (stim.size() != 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst = $urandom_range(1, 30);
			while ((burst != 0) && (stim.size() != 0)) begin
				t = stim.pop_front();
				in_valid <= 1'b1;
				opcode <= t.op;
				data_byte <= t.b;
				do @(posedge clk); while (in_stall);
				burst--;
			end
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (results_owed != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/hrp_pkg.sv
rtl/core/hrp_in_stage.sv
rtl/core/hrp_core.sv
rtl/core/http_request_parser_unit.sv
dv/http_request_parser_checker.sv
dv/tb_http_request_parser_unit.sv
